### rtl/core/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// shared types, codes and helpers of the text console character engine
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int CELL_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 4;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W     = 11;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG = 2'd1;

  localparam logic [COLOR_W-1:0] DEFAULT_FG_RST = 4'd7;
  localparam logic [COLOR_W-1:0] DEFAULT_BG_RST = 4'd0;

  // character and control codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_UP    = 8'h11;
  localparam logic [CHAR_W-1:0] CH_DOWN  = 8'h12;
  localparam logic [CHAR_W-1:0] CH_LEFT  = 8'h13;
  localparam logic [CHAR_W-1:0] CH_RIGHT = 8'h14;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // status of one put step
  typedef struct packed {
    logic write;
    logic scroll;
  } cur_stat_t;

  function automatic logic [CELL_W-1:0] make_cell(
    input logic [CHAR_W-1:0]  ch,
    input logic [COLOR_W-1:0] fg,
    input logic [COLOR_W-1:0] bg
  );
    return {bg, fg, ch};
  endfunction

endpackage

### rtl/core/tcce_cell_mem.sv
// ----------------------------------------------------------------------------
// tcce_cell_mem
// screen cell store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module tcce_cell_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [tcce_pkg::CELL_W-1:0]   wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [tcce_pkg::CELL_W-1:0]   rd_data
);

  logic [tcce_pkg::CELL_W-1:0] mem_r [DEPTH];
  logic [tcce_pkg::CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/tcce_cursor.sv
// ----------------------------------------------------------------------------
// tcce_cursor
// cursor register with row and column tracking and put-code interpretation
// ----------------------------------------------------------------------------
module tcce_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  step,
  input  logic                                  clear,
  input  logic [tcce_pkg::CHAR_W-1:0]           ch,
  output logic [$clog2(COLUMNS*ROWS)-1:0]       cursor,
  output logic [$clog2(COLUMNS*ROWS)-1:0]       wr_addr,
  output tcce_pkg::cur_stat_t                   stat
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(CELLS);
  localparam int NW    = $clog2(CELLS + 4);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int CLW   = $clog2(COLUMNS) + 1;

  logic [CW-1:0]  cur_r, cur_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [CLW-1:0] col_r, col_nxt;

  logic [NW-1:0]  cur_w;
  logic [RW-1:0]  row_w;
  logic [CLW-1:0] col_w;
  logic [CLW-1:0] col_sum;
  logic [2:0]     tab_d;
  logic           wr;
  logic [CW-1:0]  wa;
  logic           scroll;

  always_comb begin
    cur_w   = NW'(cur_r);
    row_w   = row_r;
    col_w   = col_r;
    wr      = 1'b0;
    wa      = cur_r;
    tab_d   = 3'd4 - {1'b0, cur_r[1:0]};
    col_sum = col_r + CLW'(tab_d);
    case (ch) inside
      tcce_pkg::CH_NL: begin
        cur_w = NW'(cur_r) + NW'(COLUMNS) - NW'(col_r);
        row_w = row_r + RW'(1);
        col_w = '0;
      end
      tcce_pkg::CH_TAB: begin
        cur_w = NW'(cur_r) + NW'(tab_d);
        if (col_sum >= CLW'(COLUMNS)) begin
          col_w = col_sum - CLW'(COLUMNS);
          row_w = row_r + RW'(1);
        end else begin
          col_w = col_sum;
        end
      end
      tcce_pkg::CH_BS, tcce_pkg::CH_LEFT: begin
        if (cur_r != '0) begin
          cur_w = NW'(cur_r) - NW'(1);
          wr    = (ch == tcce_pkg::CH_BS);
          wa    = cur_r - CW'(1);
          if (col_r == '0) begin
            col_w = CLW'(COLUMNS - 1);
            row_w = row_r - RW'(1);
          end else begin
            col_w = col_r - CLW'(1);
          end
        end
      end
      tcce_pkg::CH_UP: begin
        if (row_r != '0) begin
          cur_w = NW'(cur_r) - NW'(COLUMNS);
          row_w = row_r - RW'(1);
        end
      end
      tcce_pkg::CH_DOWN: begin
        if (row_r != RW'(ROWS - 1)) begin
          cur_w = NW'(cur_r) + NW'(COLUMNS);
          row_w = row_r + RW'(1);
        end
      end
      tcce_pkg::CH_NUL: begin
      end
      default: begin
        // every other code and the right arrow advance one cell
        wr    = (ch != tcce_pkg::CH_RIGHT);
        cur_w = NW'(cur_r) + NW'(1);
        if (col_r == CLW'(COLUMNS - 1)) begin
          col_w = '0;
          row_w = row_r + RW'(1);
        end else begin
          col_w = col_r + CLW'(1);
        end
      end
    endcase

    scroll = (cur_w >= NW'(CELLS));
    if (scroll) begin
      cur_nxt = CW'(CELLS - COLUMNS);
      row_nxt = RW'(ROWS - 1);
      col_nxt = '0;
    end else begin
      cur_nxt = cur_w[CW-1:0];
      row_nxt = row_w;
      col_nxt = col_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      cur_r <= '0;
      row_r <= '0;
      col_r <= '0;
    end else if (step) begin
      cur_r <= cur_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  assign cursor      = cur_r;
  assign wr_addr     = wa;
  assign stat.write  = wr;
  assign stat.scroll = scroll;

endmodule

### rtl/core/text_console_char_engine.sv
// ----------------------------------------------------------------------------
// text_console_char_engine
// text-mode screen engine: cell store, cursor, scroll and clear sequencer
// ----------------------------------------------------------------------------
// in_* carries one command per transaction (put, clear or read); every
// command gives exactly one transaction on out_*: the cursor after the step,
// the scroll flag and, for a read, the addressed cell. cfg_* writes the
// default colours used by clear and is always ready.
// A put goes through S_EXEC and S_DONE, a read in range also through
// S_READ; a clear sweeps in S_CLEAR and a put that scrolls in S_SCROLL and
// S_DRAIN before S_DONE. One command is in work at a time; its cost is set
// by the sweep over the cell memory, one cell per cycle, for clear and
// scroll.
// After reset the memory is zeroed in a pass over every cell during which
// in_stall is high; configuration writes are taken during that pass.
// A finished result sits in the output register until out_stall is low;
// the next command is taken meanwhile and waits at its end for the slot.
// ----------------------------------------------------------------------------
module text_console_char_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tcce_pkg::CMD_W-1:0]          in_command,
  input  logic [tcce_pkg::CHAR_W-1:0]         in_char_code,
  input  logic [tcce_pkg::COLOR_W-1:0]        in_fg_color,
  input  logic [tcce_pkg::COLOR_W-1:0]        in_bg_col,
  input  logic [tcce_pkg::POS_W-1:0]          in_cell_address,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tcce_pkg::POS_W-1:0]          out_cursor_idx,
  output logic                                out_scrolled,
  output logic [tcce_pkg::CHAR_W-1:0]         out_read_char,
  output logic [tcce_pkg::CHAR_W-1:0]         out_read_attr,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcce_pkg::COLOR_W-1:0]        cfg_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_EXEC, S_READ, S_CLEAR, S_SCROLL, S_DRAIN, S_DONE
  } state_t;

  state_t state_r;

  logic [tcce_pkg::CMD_W-1:0]   cmd_r;
  logic [tcce_pkg::CHAR_W-1:0]  ch_r;
  logic [tcce_pkg::COLOR_W-1:0] fg_r, bg_r;
  logic [tcce_pkg::POS_W-1:0]   addr_r;
  logic [tcce_pkg::COLOR_W-1:0] default_fg_r, default_bg_r;
  logic [AW-1:0]                j_r;
  logic                         wb_valid_r, wb_bot_r;
  logic [AW-1:0]                wb_addr_r;
  logic                         res_scr_r;
  logic [tcce_pkg::CHAR_W-1:0]  res_char_r, res_attr_r;
  logic                         out_valid_r, out_scr_r;
  logic [tcce_pkg::POS_W-1:0]   out_pos_r;
  logic [tcce_pkg::CHAR_W-1:0]  out_char_r, out_attr_r;

  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_wa, mem_ra;
  logic [tcce_pkg::CELL_W-1:0]  mem_wd, mem_rd;

  logic                         cur_step, cur_clear;
  logic [AW-1:0]                cursor, cur_wa;
  tcce_pkg::cur_stat_t          cur_stat;

  logic                         in_acc, out_free, addr_ok, j_last;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign addr_ok  = (32'(addr_r) < 32'(CELLS));
  assign j_last   = (j_r == AW'(CELLS - 1));

  assign cur_step  = (state_r == S_EXEC) && (cmd_r == tcce_pkg::CMD_PUT);
  assign cur_clear = (state_r == S_EXEC) && (cmd_r == tcce_pkg::CMD_CLEAR);

  tcce_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (cur_step),
    .clear   (cur_clear),
    .ch      (ch_r),
    .cursor  (cursor),
    .wr_addr (cur_wa),
    .stat    (cur_stat)
  );

  // memory port steering
  always_comb begin
    mem_we = 1'b0;
    mem_wa = j_r;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = j_r;
    unique case (state_r)
      S_INIT: begin
        mem_we = 1'b1;
      end
      S_EXEC: begin
        if (cmd_r == tcce_pkg::CMD_PUT) begin
          mem_we = cur_stat.write;
          mem_wa = cur_wa;
          mem_wd = tcce_pkg::make_cell(
                     (ch_r == tcce_pkg::CH_BS) ? tcce_pkg::CH_SPACE : ch_r, fg_r, bg_r);
        end
        if (cmd_r == tcce_pkg::CMD_READ) begin
          mem_re = addr_ok;
          mem_ra = AW'(addr_r);
        end
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = tcce_pkg::make_cell('0, default_fg_r, default_bg_r);
      end
      S_SCROLL, S_DRAIN: begin
        mem_we = wb_valid_r;
        mem_wa = wb_addr_r;
        mem_wd = wb_bot_r ? {mem_rd[tcce_pkg::CELL_W-1:tcce_pkg::CHAR_W],
                             tcce_pkg::CHAR_W'(0)} : mem_rd;
        mem_re = (state_r == S_SCROLL);
        mem_ra = (j_r < AW'(CELLS - COLUMNS)) ? j_r + AW'(COLUMNS) : j_r;
      end
      default: begin
      end
    endcase
  end

  tcce_cell_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      j_r          <= '0;
      wb_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      default_fg_r <= tcce_pkg::DEFAULT_FG_RST;
      default_bg_r <= tcce_pkg::DEFAULT_BG_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tcce_pkg::CFG_DEFAULT_FG) begin
          default_fg_r <= cfg_data;
        end
        if (cfg_index == tcce_pkg::CFG_DEFAULT_BG) begin
          default_bg_r <= cfg_data;
        end
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          if (j_last) begin
            j_r     <= '0;
            state_r <= S_IDLE;
          end else begin
            j_r <= j_r + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            cmd_r   <= in_command;
            ch_r    <= in_char_code;
            fg_r    <= in_fg_color;
            bg_r    <= in_bg_col;
            addr_r  <= in_cell_address;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_scr_r  <= 1'b0;
          res_char_r <= '0;
          res_attr_r <= '0;
          j_r        <= '0;
          wb_valid_r <= 1'b0;
          unique case (cmd_r)
            tcce_pkg::CMD_PUT: begin
              res_scr_r <= cur_stat.scroll;
              state_r   <= cur_stat.scroll ? S_SCROLL : S_DONE;
            end
            tcce_pkg::CMD_CLEAR: state_r <= S_CLEAR;
            tcce_pkg::CMD_READ:  state_r <= addr_ok ? S_READ : S_DONE;
            default:             state_r <= S_DONE;
          endcase
        end
        S_READ: begin
          res_char_r <= mem_rd[tcce_pkg::CHAR_W-1:0];
          res_attr_r <= mem_rd[tcce_pkg::CELL_W-1:tcce_pkg::CHAR_W];
          state_r    <= S_DONE;
        end
        S_CLEAR: begin
          if (j_last) begin
            j_r     <= '0;
            state_r <= S_DONE;
          end else begin
            j_r <= j_r + AW'(1);
          end
        end
        S_SCROLL: begin
          wb_valid_r <= 1'b1;
          wb_addr_r  <= j_r;
          wb_bot_r   <= (j_r >= AW'(CELLS - COLUMNS));
          if (j_last) begin
            j_r     <= '0;
            state_r <= S_DRAIN;
          end else begin
            j_r <= j_r + AW'(1);
          end
        end
        S_DRAIN: begin
          wb_valid_r <= 1'b0;
          state_r    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_pos_r   <= tcce_pkg::POS_W'(cursor);
            out_scr_r   <= res_scr_r;
            out_char_r  <= res_char_r;
            out_attr_r  <= res_attr_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_cursor_idx = out_pos_r;
  assign out_scrolled   = out_scr_r;
  assign out_read_char  = out_char_r;
  assign out_read_attr  = out_attr_r;

  // no command is taken during the clearing pass that follows reset
  a_init_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during memory clearing pass");

  // the cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cursor) < 32'(CELLS))
    else $error("cursor outside screen");

  // a scrolled result always reports the start of the last row
  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_scr_r |-> out_pos_r == tcce_pkg::POS_W'(CELLS - COLUMNS))
    else $error("scroll result with wrong cursor");

  // the cell store is untouched while waiting for a command
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mem_we)
    else $error("memory written while idle");

endmodule

### sim/text_console_char_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_engine_checker
// watches the command, result and register channels of the console engine,
// keeps its own copy of the screen, cursor and default colours, works out
// the reply to every accepted command and compares each result transaction
// field by field with the oldest reply still due
// ----------------------------------------------------------------------------
module text_console_char_engine_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [tcce_pkg::CMD_W-1:0]     in_command,
  input  logic [tcce_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcce_pkg::COLOR_W-1:0]   in_fg_color,
  input  logic [tcce_pkg::COLOR_W-1:0]   in_bg_col,
  input  logic [tcce_pkg::POS_W-1:0]     in_cell_address,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [tcce_pkg::POS_W-1:0]     out_cursor_idx,
  input  logic                           out_scrolled,
  input  logic [tcce_pkg::CHAR_W-1:0]    out_read_char,
  input  logic [tcce_pkg::CHAR_W-1:0]    out_read_attr,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcce_pkg::COLOR_W-1:0]   cfg_data,
  output int                             fail_count,
  output int                             pending
);

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [tcce_pkg::POS_W-1:0]  cursor_idx;
    logic                        scrolled;
    logic [tcce_pkg::CHAR_W-1:0] read_char;
    logic [tcce_pkg::CHAR_W-1:0] read_attr;
  } screen_reply_t;

  logic [tcce_pkg::CELL_W-1:0]  screen [CELLS];
  int unsigned                  caret;
  logic [tcce_pkg::COLOR_W-1:0] blank_fg;
  logic [tcce_pkg::COLOR_W-1:0] blank_bg;
  screen_reply_t                replies_due [$];
  int                           faults;
  int                           due_count;
  int                           result_no;

  assign fail_count = faults;
  assign pending    = due_count;

  task automatic report_fault(input string msg);
    faults++;
    if (faults <= 100) begin
      $display("%0t: result %0d: %s", $realtime, result_no, msg);
    end
  endtask

  function automatic screen_reply_t console_step(
    input logic [tcce_pkg::CMD_W-1:0]   cmd,
    input logic [tcce_pkg::CHAR_W-1:0]  ch,
    input logic [tcce_pkg::COLOR_W-1:0] fg,
    input logic [tcce_pkg::COLOR_W-1:0] bg,
    input logic [tcce_pkg::POS_W-1:0]   addr
  );
    screen_reply_t r;
    int unsigned   pos;
    int            i;
    r   = '0;
    pos = caret;
    case (cmd)
      tcce_pkg::CMD_PUT: begin
        case (ch)
          tcce_pkg::CH_NL:    pos = pos + COLUMNS - (pos % COLUMNS);
          tcce_pkg::CH_TAB:   pos = pos + 4 - (pos % 4);
          tcce_pkg::CH_BS: begin
            if (pos > 0) begin
              pos = pos - 1;
              screen[pos] = {bg, fg, tcce_pkg::CH_SPACE};
            end
          end
          tcce_pkg::CH_UP:    if (pos >= COLUMNS) pos = pos - COLUMNS;
          tcce_pkg::CH_DOWN:  if (pos + COLUMNS < CELLS) pos = pos + COLUMNS;
          tcce_pkg::CH_LEFT:  if (pos > 0) pos = pos - 1;
          tcce_pkg::CH_RIGHT: pos = pos + 1;
          tcce_pkg::CH_NUL:   ;
          default: begin
            screen[pos] = {bg, fg, ch};
            pos = pos + 1;
          end
        endcase
        if (pos >= CELLS) begin
          for (i = COLUMNS; i < CELLS; i++) screen[i - COLUMNS] = screen[i];
          for (i = CELLS - COLUMNS; i < CELLS; i++) screen[i][tcce_pkg::CHAR_W-1:0] = '0;
          pos        = CELLS - COLUMNS;
          r.scrolled = 1'b1;
        end
      end
      tcce_pkg::CMD_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen[i] = {blank_bg, blank_fg, tcce_pkg::CH_NUL};
        pos = 0;
      end
      tcce_pkg::CMD_READ: begin
        if (addr < CELLS) begin
          r.read_char = screen[addr][tcce_pkg::CHAR_W-1:0];
          r.read_attr = screen[addr][tcce_pkg::CELL_W-1:tcce_pkg::CHAR_W];
        end
      end
      default: ;
    endcase
    caret        = pos;
    r.cursor_idx = pos[tcce_pkg::POS_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    screen_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) screen[i] = '0;
      caret     = 0;
      blank_fg  = tcce_pkg::DEFAULT_FG_RST;
      blank_bg  = tcce_pkg::DEFAULT_BG_RST;
      replies_due.delete();
      faults    = 0;
      due_count = 0;
      result_no = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcce_pkg::CFG_DEFAULT_FG: blank_fg = cfg_data;
          tcce_pkg::CFG_DEFAULT_BG: blank_bg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          report_fault("result transaction with no command outstanding");
        end else begin
          want = replies_due.pop_front();
          if (out_cursor_idx !== want.cursor_idx)
            report_fault($sformatf("cursor_idx got %0d expected %0d",
                                   out_cursor_idx, want.cursor_idx));
          if (out_scrolled !== want.scrolled)
            report_fault($sformatf("scrolled got %0b expected %0b",
                                   out_scrolled, want.scrolled));
          if (out_read_char !== want.read_char)
            report_fault($sformatf("read_char got %02h expected %02h",
                                   out_read_char, want.read_char));
          if (out_read_attr !== want.read_attr)
            report_fault($sformatf("read_attr got %02h expected %02h",
                                   out_read_attr, want.read_attr));
        end
        result_no++;
      end
      if (in_valid && !in_stall) begin
        replies_due.push_back(console_step(in_command, in_char_code, in_fg_color,
                                           in_bg_col, in_cell_address));
      end
      due_count = replies_due.size();
    end
  end

endmodule

### sim/text_console_char_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_engine_tb
// drives the console engine with a directed set of commands and then with
// phases of random text, cursor moves, reads and clears under several
// default colour settings, with random gaps on the command side and random
// stalls on the result side; the checker does the prediction and comparison
// ----------------------------------------------------------------------------
module text_console_char_engine_tb;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int PHASES  = 6;
  localparam int PHASE_ITEMS = 242;

  localparam logic [tcce_pkg::CMD_W-1:0]     CMD_UNUSED  = 2'd3;
  localparam logic [tcce_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [tcce_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [tcce_pkg::CMD_W-1:0]   command;
    logic [tcce_pkg::CHAR_W-1:0]  char_code;
    logic [tcce_pkg::COLOR_W-1:0] fg_color;
    logic [tcce_pkg::COLOR_W-1:0] bg_col;
    logic [tcce_pkg::POS_W-1:0]   cell_address;
  } console_cmd_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [tcce_pkg::CMD_W-1:0]     in_command;
  logic [tcce_pkg::CHAR_W-1:0]    in_char_code;
  logic [tcce_pkg::COLOR_W-1:0]   in_fg_color;
  logic [tcce_pkg::COLOR_W-1:0]   in_bg_col;
  logic [tcce_pkg::POS_W-1:0]     in_cell_address;
  logic                           out_valid;
  logic                           out_stall;
  logic [tcce_pkg::POS_W-1:0]     out_cursor_idx;
  logic                           out_scrolled;
  logic [tcce_pkg::CHAR_W-1:0]    out_read_char;
  logic [tcce_pkg::CHAR_W-1:0]    out_read_attr;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tcce_pkg::COLOR_W-1:0]   cfg_data;
  int                             fail_count;
  int                             pending;
  bit                             quiet_phase;
  int                             stall_left;

  text_console_char_engine #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (.*);

  text_console_char_engine_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic console_cmd_t mk_cmd(
    input logic [tcce_pkg::CMD_W-1:0]   cmd,
    input logic [tcce_pkg::CHAR_W-1:0]  ch,
    input logic [tcce_pkg::COLOR_W-1:0] fg,
    input logic [tcce_pkg::COLOR_W-1:0] bg,
    input logic [tcce_pkg::POS_W-1:0]   addr
  );
    console_cmd_t c;
    c.command      = cmd;
    c.char_code    = ch;
    c.fg_color     = fg;
    c.bg_col       = bg;
    c.cell_address = addr;
    return c;
  endfunction

  function automatic console_cmd_t random_cmd();
    console_cmd_t c;
    int r;
    c = mk_cmd(tcce_pkg::CMD_PUT, tcce_pkg::CHAR_W'($urandom_range(0, 255)),
               tcce_pkg::COLOR_W'($urandom_range(0, 15)),
               tcce_pkg::COLOR_W'($urandom_range(0, 15)),
               tcce_pkg::POS_W'($urandom_range(0, 2047)));
    r = $urandom_range(0, 99);
    if (r < 2) begin
      c.command = CMD_UNUSED;
    end else if (r < 3) begin
      c.command = tcce_pkg::CMD_CLEAR;
    end else if (r < 20) begin
      c.command = tcce_pkg::CMD_READ;
      if ($urandom_range(0, 4) != 0)
        c.cell_address = tcce_pkg::POS_W'($urandom_range(0, CELLS - 1));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8)       c.char_code = tcce_pkg::CH_NL;
      else if (r < 11) c.char_code = tcce_pkg::CH_TAB;
      else if (r < 14) c.char_code = tcce_pkg::CH_BS;
      else if (r < 16) c.char_code = tcce_pkg::CH_UP;
      else if (r < 18) c.char_code = tcce_pkg::CH_DOWN;
      else if (r < 20) c.char_code = tcce_pkg::CH_LEFT;
      else if (r < 22) c.char_code = tcce_pkg::CH_RIGHT;
      else if (r < 23) c.char_code = tcce_pkg::CH_NUL;
      else if (r < 60) c.char_code = tcce_pkg::CHAR_W'($urandom_range(8'h20, 8'h7e));
    end
    return c;
  endfunction

  task automatic send_cmd(input console_cmd_t c);
    int gap;
    gap = pick_gap(quiet_phase);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= c.command;
    in_char_code    <= c.char_code;
    in_fg_color     <= c.fg_color;
    in_bg_col       <= c.bg_col;
    in_cell_address <= c.cell_address;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tcce_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tcce_pkg::COLOR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // result side stall pattern
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(quiet_phase);
      end
    end
  end

  initial begin
    logic [tcce_pkg::COLOR_W-1:0] fg_plan [PHASES];
    logic [tcce_pkg::COLOR_W-1:0] bg_plan [PHASES];
    fg_plan = '{4'd15, 4'd0, 4'd15, 4'd0, 4'd7, 4'd7};
    bg_plan = '{4'd15, 4'd0, 4'd0, 4'd15, 4'd0, 4'd0};
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_command      = tcce_pkg::CMD_PUT;
    in_char_code    = tcce_pkg::CH_NUL;
    in_fg_color     = '0;
    in_bg_col       = '0;
    in_cell_address = '0;
    cfg_valid       = 1'b0;
    cfg_index       = tcce_pkg::CFG_DEFAULT_FG;
    cfg_data        = '0;
    quiet_phase     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed commands, reset colours
    send_cmd(mk_cmd(tcce_pkg::CMD_READ, tcce_pkg::CH_NUL,   4'd0,  4'd0,  11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_PUT,  8'h41,              4'd15, 4'd15, 11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_PUT,  8'hff,              4'd0,  4'd0,  11'd2047));
    send_cmd(mk_cmd(tcce_pkg::CMD_PUT,  tcce_pkg::CH_NUL,   4'd3,  4'd5,  11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_PUT,  tcce_pkg::CH_TAB,   4'd1,  4'd2,  11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_PUT,  tcce_pkg::CH_TAB,   4'd1,  4'd2,  11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_PUT,  tcce_pkg::CH_NL,    4'd1,  4'd2,  11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_PUT,  tcce_pkg::CH_UP,    4'd1,  4'd2,  11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_PUT,  tcce_pkg::CH_UP,    4'd1,  4'd2,  11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_PUT,  tcce_pkg::CH_DOWN,  4'd1,  4'd2,  11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_PUT,  tcce_pkg::CH_RIGHT, 4'd1,  4'd2,  11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_PUT,  tcce_pkg::CH_LEFT,  4'd1,  4'd2,  11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_PUT,  tcce_pkg::CH_BS,    4'd12, 4'd10, 11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_READ, tcce_pkg::CH_NUL,   4'd0,  4'd0,  11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_READ, tcce_pkg::CH_NUL,   4'd0,  4'd0,  11'd1));
    send_cmd(mk_cmd(tcce_pkg::CMD_READ, tcce_pkg::CH_NUL,   4'd0,  4'd0,  11'd79));
    send_cmd(mk_cmd(tcce_pkg::CMD_READ, tcce_pkg::CH_NUL,   4'd0,  4'd0,
                    tcce_pkg::POS_W'(CELLS - 1)));
    send_cmd(mk_cmd(tcce_pkg::CMD_READ, tcce_pkg::CH_NUL,   4'd0,  4'd0,
                    tcce_pkg::POS_W'(CELLS)));
    send_cmd(mk_cmd(tcce_pkg::CMD_READ, tcce_pkg::CH_NUL,   4'd0,  4'd0,  11'd2047));
    send_cmd(mk_cmd(CMD_UNUSED, tcce_pkg::CHAR_W'($urandom_range(0, 255)),
                    tcce_pkg::COLOR_W'($urandom_range(0, 15)),
                    tcce_pkg::COLOR_W'($urandom_range(0, 15)),
                    tcce_pkg::POS_W'($urandom_range(0, 2047))));
    send_cmd(mk_cmd(tcce_pkg::CMD_CLEAR, tcce_pkg::CH_NUL,  4'd0,  4'd0,  11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_PUT,  tcce_pkg::CH_LEFT,  4'd0,  4'd0,  11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_PUT,  tcce_pkg::CH_BS,    4'd0,  4'd0,  11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_READ, tcce_pkg::CH_NUL,   4'd0,  4'd0,  11'd0));
    send_cmd(mk_cmd(tcce_pkg::CMD_PUT,  8'h80,              4'd9,  4'd6,  11'd0));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      quiet_phase = (ph == 2);
      if (ph >= 4) begin
        fg_plan[ph] = tcce_pkg::COLOR_W'($urandom_range(0, 15));
        bg_plan[ph] = tcce_pkg::COLOR_W'($urandom_range(0, 15));
      end
      write_reg(tcce_pkg::CFG_DEFAULT_FG, fg_plan[ph]);
      write_reg(tcce_pkg::CFG_DEFAULT_BG, bg_plan[ph]);
      if (ph == 1 || ph == 4) begin
        write_reg(CFG_SPARE_A, tcce_pkg::COLOR_W'($urandom_range(0, 15)));
        write_reg(CFG_SPARE_B, tcce_pkg::COLOR_W'($urandom_range(0, 15)));
      end
      send_cmd(mk_cmd(tcce_pkg::CMD_CLEAR, tcce_pkg::CHAR_W'($urandom_range(0, 255)),
                      tcce_pkg::COLOR_W'($urandom_range(0, 15)),
                      tcce_pkg::COLOR_W'($urandom_range(0, 15)),
                      tcce_pkg::POS_W'($urandom_range(0, 2047))));
      for (int k = 0; k < PHASE_ITEMS; k++) send_cmd(random_cmd());
      drain();
    end

    repeat (CELLS + 16) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
